FILE: rtl/tbbs_pkg.sv
// Shared types, widths and register codes of the transformed bounding box and sphere block.
package tbbs_pkg;

  localparam int COORD_W    = 16;
  localparam int COEF_W     = 16;
  localparam int PROD_W     = COORD_W + COEF_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int FRAC_SHIFT = 14;
  localparam int Q_W        = ACC_W - FRAC_SHIFT;
  localparam int VAL_W      = 24;
  localparam int REG_W      = 48;
  localparam int IDX_W      = 3;
  localparam int SQ_W       = 2 * VAL_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int ROOT_STEPS = SUM_W / 2;
  localparam int STEP_W     = 5;
  localparam int IN_W       = 3 * COORD_W;
  localparam int OUT_W      = 10 * VAL_W;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [REG_W-1:0] X_COEFFS_RST = 48'h4000_0000_0000;
  localparam logic [REG_W-1:0] Y_COEFFS_RST = 48'h0000_4000_0000;
  localparam logic [REG_W-1:0] Z_COEFFS_RST = 48'h0000_0000_4000;

  localparam logic [VAL_W-1:0] VAL_MAX = 24'h7F_FFFF;
  localparam logic [VAL_W-1:0] VAL_MIN = 24'h80_0000;
  localparam logic [VAL_W-1:0] RAD_MAX = 24'hFF_FFFF;

  typedef enum logic [IDX_W-1:0] {
    REG_X_COEFFS  = 3'd0,
    REG_Y_COEFFS  = 3'd1,
    REG_Z_COEFFS  = 3'd2,
    REG_TRANS_X   = 3'd3,
    REG_TRANS_Y   = 3'd4,
    REG_TRANS_Z   = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [2:0][REG_W-1:0] coeffs;
    logic [2:0][VAL_W-1:0] trans;
  } cfg_t;

  typedef struct packed {
    logic [2:0][VAL_W-1:0] hi;
    logic [2:0][VAL_W-1:0] lo;
  } box_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HALF,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_OUT
  } back_state_t;

endpackage

FILE: rtl/transformed_bounding_box_sphere.sv
// Top level: transformed bounding box and bounding sphere of a vertex stream.
// Vertices enter on the in_ channel, one per cycle; in_tlast marks the last
// vertex of a mesh. Each vertex is transformed by the 3x3 coefficient
// registers plus translation, saturated to Q24.0, and folded into the
// running per-axis min and max. The last vertex closes the box, which
// passes through a short queue to the back part. The back part forms the
// center and the radius (square root, one result bit per cycle) and presents
// one result item on the out_ channel per mesh.
// The back part steps through its half, square, sum, root and output states
// and takes the next box from the queue only when back in its idle state.
// Throughput: one vertex per cycle while in_tready is high; the mesh result
// rate is set by the root iteration. Meshes arriving faster than that fill the
// queue, and the front stalls (in_tready low) until a box is taken.
// A stalled receiver holds the result; the back part finishes the next box
// and waits in its output state. Reset clears the pipeline, the queue and the
// result valid, and loads the identity transform with zero translation.
module transformed_bounding_box_sphere import tbbs_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0] cfg_wdata,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,  // vertex_x, vertex_y, vertex_z
  input  logic             in_tlast,  // last_vertex
  output logic             out_tvalid,
  input  logic             out_tready,
  // box_min_x/y/z, box_max_x/y/z, center_x/y/z, radius
  output logic [OUT_W-1:0] out_tdata
);

  cfg_t cfg_r;
  logic push, full, pop, empty;
  box_t push_box, head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coeffs[0] <= X_COEFFS_RST;
      cfg_r.coeffs[1] <= Y_COEFFS_RST;
      cfg_r.coeffs[2] <= Z_COEFFS_RST;
      cfg_r.trans     <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_X_COEFFS: cfg_r.coeffs[0] <= cfg_wdata;
        REG_Y_COEFFS: cfg_r.coeffs[1] <= cfg_wdata;
        REG_Z_COEFFS: cfg_r.coeffs[2] <= cfg_wdata;
        REG_TRANS_X:  cfg_r.trans[0]  <= cfg_wdata[VAL_W-1:0];
        REG_TRANS_Y:  cfg_r.trans[1]  <= cfg_wdata[VAL_W-1:0];
        REG_TRANS_Z:  cfg_r.trans[2]  <= cfg_wdata[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  tbbs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_data    (in_tdata),
    .in_last    (in_tlast),
    .queue_full (full),
    .push       (push),
    .box        (push_box)
  );

  tbbs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_box (push_box),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  tbbs_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .queue_empty (empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_data    (out_tdata)
  );

endmodule

FILE: rtl/tbbs_front.sv
// Vertex transform pipeline and running box tracker.
module tbbs_front import tbbs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [IN_W-1:0]    in_data,
  input  logic               in_last,
  input  logic               queue_full,
  output logic               push,
  output box_t               box
);

  logic                        en;
  logic                        v1_r, v2_r, v3_r, v4_r;
  logic                        last1_r, last2_r, last3_r, last4_r;
  logic [2:0][COORD_W-1:0]     crd1_r;
  logic [2:0][2:0][PROD_W-1:0] prod2_r;
  logic [2:0][Q_W-1:0]         q3_r;
  logic [2:0][VAL_W-1:0]       t4_r;
  logic [2:0][VAL_W-1:0]       min_r, max_r;
  logic [2:0][VAL_W-1:0]       min_nxt, max_nxt;
  logic                        first_r;
  logic [2:0][2:0][PROD_W-1:0] prod_nxt;
  logic [2:0][Q_W-1:0]         q_nxt;
  logic [2:0][VAL_W-1:0]       t_nxt;
  logic [2:0][ACC_W-1:0]       acc;
  logic [2:0][VAL_W:0]         tsum;

  assign en       = !(v4_r && last4_r && queue_full);
  assign in_ready = en;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int k = 0; k < 3; k++) begin
        prod_nxt[a][k] = PROD_W'($signed(crd1_r[k]) *
                                 $signed(cfg.coeffs[a][(2-k)*COEF_W +: COEF_W]));
      end
      acc[a] = ACC_W'($signed(prod2_r[a][0])) + ACC_W'($signed(prod2_r[a][1])) +
               ACC_W'($signed(prod2_r[a][2]));
      q_nxt[a] = acc[a][ACC_W-1:FRAC_SHIFT];
      tsum[a] = (VAL_W+1)'($signed(q3_r[a])) + (VAL_W+1)'($signed(cfg.trans[a]));
      if (tsum[a][VAL_W] != tsum[a][VAL_W-1]) begin
        t_nxt[a] = tsum[a][VAL_W] ? VAL_MIN : VAL_MAX;
      end else begin
        t_nxt[a] = tsum[a][VAL_W-1:0];
      end
      min_nxt[a] = (first_r || ($signed(t4_r[a]) < $signed(min_r[a]))) ? t4_r[a] : min_r[a];
      max_nxt[a] = (first_r || ($signed(t4_r[a]) > $signed(max_r[a]))) ? t4_r[a] : max_r[a];
    end
  end

  assign push   = v4_r && last4_r && en;
  assign box.lo = min_nxt;
  assign box.hi = max_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      first_r <= 1'b1;
      min_r   <= '0;
      max_r   <= '0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      if (v4_r) begin
        min_r   <= min_nxt;
        max_r   <= max_nxt;
        first_r <= last4_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      crd1_r  <= in_data;
      last1_r <= in_last;
      prod2_r <= prod_nxt;
      last2_r <= last1_r;
      q3_r    <= q_nxt;
      last3_r <= last2_r;
      t4_r    <= t_nxt;
      last4_r <= last3_r;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    push |-> ($signed(box.lo[0]) <= $signed(box.hi[0])) &&
             ($signed(box.lo[1]) <= $signed(box.hi[1])) &&
             ($signed(box.lo[2]) <= $signed(box.hi[2])))
    else $error("box min above max");

  assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && last4_r && queue_full) |=> $stable(t4_r) && v4_r)
    else $error("front advanced while queue full");

endmodule

FILE: rtl/tbbs_queue.sv
// Short queue of finished boxes between the front and back parts.
module tbbs_queue import tbbs_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  box_t push_box,
  output logic full,
  input  logic pop,
  output logic empty,
  output box_t head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  box_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_box;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("push into full queue");

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CNT_W'(DEPTH))
    else $error("queue count overflow");

endmodule

FILE: rtl/tbbs_back.sv
// Sphere center and radius sequencer with the result register.
module tbbs_back import tbbs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             queue_empty,
  input  box_t             head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] out_data
);

  back_state_t           state_r, state_nxt;
  box_t                  box_r;
  logic [2:0][VAL_W-1:0] half_r, center_r;
  logic [2:0][SQ_W-1:0]  sqr_r;
  logic [SUM_W-1:0]      rem_r, root_r, bit_r;
  logic [STEP_W-1:0]     step_r;
  logic                  out_valid_r;
  logic [OUT_W-1:0]      out_data_r;
  logic [SUM_W-1:0]      trial;
  logic                  take;
  logic                  load_out;
  logic [VAL_W-1:0]      rad;
  logic [2:0][VAL_W:0]   diff;

  assign trial = root_r + bit_r;
  assign take  = (rem_r >= trial);
  assign rad   = (|root_r[SUM_W-1:VAL_W]) ? RAD_MAX : root_r[VAL_W-1:0];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      diff[a] = {box_r.hi[a][VAL_W-1], box_r.hi[a]} - {box_r.lo[a][VAL_W-1], box_r.lo[a]};
    end
  end

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!queue_empty) begin
          pop       = 1'b1;
          state_nxt = ST_HALF;
        end
      end
      ST_HALF:   state_nxt = ST_SQUARE;
      ST_SQUARE: state_nxt = ST_SUM;
      ST_SUM:    state_nxt = ST_ROOT;
      ST_ROOT: begin
        if (step_r == '0) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      box_r <= head;
    end
    if (state_r == ST_HALF) begin
      for (int a = 0; a < 3; a++) begin
        half_r[a]   <= diff[a][VAL_W:1];
        center_r[a] <= box_r.lo[a] + diff[a][VAL_W:1];
      end
    end
    if (state_r == ST_SQUARE) begin
      for (int a = 0; a < 3; a++) begin
        sqr_r[a] <= half_r[a] * half_r[a];
      end
    end
    if (state_r == ST_SUM) begin
      rem_r  <= SUM_W'(sqr_r[0]) + SUM_W'(sqr_r[1]) + SUM_W'(sqr_r[2]);
      root_r <= '0;
      bit_r  <= SUM_W'(1) << (SUM_W - 2);
      step_r <= STEP_W'(ROOT_STEPS - 1);
    end
    if (state_r == ST_ROOT) begin
      if (take) begin
        rem_r  <= rem_r - trial;
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r  <= bit_r >> 2;
      step_r <= step_r - 1'b1;
    end
    if (load_out) begin
      out_data_r <= {rad, center_r[2], center_r[1], center_r[0],
                     box_r.hi[2], box_r.hi[1], box_r.hi[0],
                     box_r.lo[2], box_r.lo[1], box_r.lo[0]};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result raised outside output state");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROOT && step_r == '0) |=> state_r == ST_OUT)
    else $error("root iteration count mismatch");

endmodule

FILE: dv/tb_transformed_bounding_box_sphere.sv
// Testbench for the transformed bounding box and sphere block: directed meshes, then random ones.
`timescale 1ns / 100ps

module tb_transformed_bounding_box_sphere;
  import tbbs_pkg::*;

  localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam int STALL_LIMIT    = 4000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int SETTLE_CYCLES  = 48;
  localparam int PHASES         = 8;
  localparam int PHASE_VERTICES = 242;
  localparam int CALM_PHASE     = 4;

  typedef logic [9:0][VAL_W-1:0] mesh_bounds_t;

  typedef struct {
    logic [COORD_W-1:0] vx;
    logic [COORD_W-1:0] vy;
    logic [COORD_W-1:0] vz;
    bit                 last;
    bit                 typed;
    mesh_bounds_t       want;
  } vertex_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_wdata = '0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             in_tlast = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  cfg_t                     model_cfg;
  logic signed [VAL_W-1:0]  lo_q [3];
  logic signed [VAL_W-1:0]  hi_q [3];
  bit                       fresh_mesh;
  mesh_bounds_t             bounds_q [$];
  vertex_row_t              script [$];
  bit                       calm = 1'b0;
  int                       mismatches = 0;
  int                       stall_cycles = 0;

  string field_name [10] = '{"box_min_x", "box_min_y", "box_min_z", "box_max_x", "box_max_y",
                             "box_max_z", "center_x", "center_y", "center_z", "radius"};

  transformed_bounding_box_sphere i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  function automatic logic signed [VAL_W-1:0] warp_axis(input int a,
      input logic signed [COORD_W-1:0] vx, vy, vz);
    longint acc;
    acc = longint'(vx) * longint'($signed(model_cfg.coeffs[a][47:32]))
        + longint'(vy) * longint'($signed(model_cfg.coeffs[a][31:16]))
        + longint'(vz) * longint'($signed(model_cfg.coeffs[a][15:0]));
    acc = (acc >>> FRAC_SHIFT) + longint'($signed(model_cfg.trans[a]));
    if (acc > longint'($signed(VAL_MAX))) acc = longint'($signed(VAL_MAX));
    if (acc < longint'($signed(VAL_MIN))) acc = longint'($signed(VAL_MIN));
    return acc[VAL_W-1:0];
  endfunction

  function automatic longint unsigned int_root(input longint unsigned v);
    longint unsigned rem, root, b;
    rem = v;
    root = 0;
    b = 64'h1 << 62;
    while (b > rem) b >>= 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  // fold one vertex into the running box; returns 1 when the mesh closes
  function automatic bit fold_vertex(input logic signed [COORD_W-1:0] vx, vy, vz,
      input bit last, output mesh_bounds_t res);
    logic signed [VAL_W-1:0] t;
    longint half;
    longint unsigned sq;
    longint unsigned rad;
    res = '0;
    for (int a = 0; a < 3; a++) begin
      t = warp_axis(a, vx, vy, vz);
      if (fresh_mesh) begin
        lo_q[a] = t;
        hi_q[a] = t;
      end else begin
        if (t < lo_q[a]) lo_q[a] = t;
        if (t > hi_q[a]) hi_q[a] = t;
      end
    end
    fresh_mesh = last;
    if (!last) return 1'b0;
    sq = 0;
    for (int a = 0; a < 3; a++) begin
      half = (longint'(hi_q[a]) - longint'(lo_q[a])) / 2;
      sq += longint'(half * half);
      res[a] = lo_q[a];
      res[a+3] = hi_q[a];
      res[a+6] = lo_q[a] + half[VAL_W-1:0];
    end
    rad = int_root(sq);
    if (rad > longint'(RAD_MAX)) rad = longint'(RAD_MAX);
    res[9] = rad[VAL_W-1:0];
    return 1'b1;
  endfunction

  function automatic mesh_bounds_t pack_bounds(input int lx, ly, lz, hx, hy, hz,
      cx, cy, cz, r);
    mesh_bounds_t b;
    b[0] = lx[VAL_W-1:0];
    b[1] = ly[VAL_W-1:0];
    b[2] = lz[VAL_W-1:0];
    b[3] = hx[VAL_W-1:0];
    b[4] = hy[VAL_W-1:0];
    b[5] = hz[VAL_W-1:0];
    b[6] = cx[VAL_W-1:0];
    b[7] = cy[VAL_W-1:0];
    b[8] = cz[VAL_W-1:0];
    b[9] = r[VAL_W-1:0];
    return b;
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    logic [COORD_W-1:0] v;
    case ($urandom_range(3))
      0: v = COORD_W'($urandom_range(16'h01FF));
      1: v = COORD_W'(-$urandom_range(16'h01FF));
      2: v = $urandom_range(1) ? 16'h7FFF : 16'h8000;
      default: v = COORD_W'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [COEF_W-1:0] pick_weight();
    logic [COEF_W-1:0] w;
    case ($urandom_range(3))
      0: w = COEF_W'(16'h4000 + $urandom_range(16'h0FFF) - 16'h0800);
      1: w = COEF_W'(-($urandom_range(16'h07FF)));
      2: w = $urandom_range(1) ? 16'h7FFF : 16'h8000;
      default: w = COEF_W'($urandom);
    endcase
    return w;
  endfunction

  // leave cfg_wr_en high; the caller drops it after the last write
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_X_COEFFS, REG_Y_COEFFS, REG_Z_COEFFS: model_cfg.coeffs[idx] = val;
      REG_TRANS_X, REG_TRANS_Y, REG_TRANS_Z: model_cfg.trans[idx - REG_TRANS_X] = val[VAL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input int phase);
    logic [REG_W-1:0] junk;
    logic [VAL_W-1:0] shift;
    logic [REG_W-1:0] coeffs;
    write_reg(REG_SPARE_A, REG_W'({$urandom, $urandom}));
    write_reg(REG_SPARE_B, REG_W'({$urandom, $urandom}));
    for (int a = 0; a < 3; a++) begin
      junk = REG_W'({$urandom, $urandom});
      case (phase)
        1: begin
          coeffs = {3{16'h7FFF}};
          shift = VAL_MAX;
        end
        2: begin
          coeffs = {3{16'h8000}};
          shift = VAL_MIN;
        end
        3: begin
          coeffs = '0;
          shift = VAL_W'($urandom);
        end
        default: begin
          coeffs = {pick_weight(), pick_weight(), pick_weight()};
          shift = $urandom_range(1) ? VAL_W'($urandom) : VAL_W'($signed($urandom_range(8191)) - 4096);
        end
      endcase
      write_reg(IDX_W'(REG_X_COEFFS + a), coeffs);
      write_reg(IDX_W'(REG_TRANS_X + a), {junk[REG_W-1:VAL_W], shift});
    end
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_vertex(input logic [COORD_W-1:0] vx, vy, vz, input bit last,
      input bit typed, input mesh_bounds_t typed_r);
    mesh_bounds_t r;
    while (!calm && $urandom_range(99) < 33) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {vz, vy, vx};
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    if (fold_vertex(vx, vy, vz, last, r)) bounds_q.push_back(typed ? typed_r : r);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (bounds_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 33);
    end
  end

  always @(posedge clk) begin
    mesh_bounds_t want;
    mesh_bounds_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (bounds_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h", got);
      end else begin
        want = bounds_q.pop_front();
        for (int f = 0; f < 10; f++) begin
          if (got[f] !== want[f]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%s: expected %h, got %h", field_name[f], want[f], got[f]);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int sent;
    int len;
    model_cfg.coeffs[REG_X_COEFFS] = X_COEFFS_RST;
    model_cfg.coeffs[REG_Y_COEFFS] = Y_COEFFS_RST;
    model_cfg.coeffs[REG_Z_COEFFS] = Z_COEFFS_RST;
    model_cfg.trans = '0;
    for (int a = 0; a < 3; a++) begin
      lo_q[a] = '0;
      hi_q[a] = '0;
    end
    fresh_mesh = 1'b1;

    script.push_back('{16'h7FFF, 16'h8000, 16'h0000, 1, 1,
      pack_bounds(32767, -32768, 0, 32767, -32768, 0, 32767, -32768, 0, 0)});
    script.push_back('{16'h8000, 16'h7FFF, 16'h0001, 1, 1,
      pack_bounds(-32768, 32767, 1, -32768, 32767, 1, -32768, 32767, 1, 0)});
    script.push_back('{16'h0000, 16'h0000, 16'h0000, 0, 0, '0});
    script.push_back('{16'h0100, 16'h0000, 16'h0000, 0, 0, '0});
    script.push_back('{16'h0000, 16'h0200, 16'h0000, 0, 0, '0});
    script.push_back('{16'h0000, 16'h0000, 16'hFD00, 1, 1,
      pack_bounds(0, 0, -768, 256, 512, 0, 128, 256, -384, 478)});
    script.push_back('{16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 0, '0});
    script.push_back('{16'h8000, 16'h8000, 16'h8000, 1, 0, '0});
    script.push_back('{16'h0001, 16'h0000, 16'hFFFF, 0, 0, '0});
    script.push_back('{16'h0000, 16'h0001, 16'h0000, 1, 0, '0});
    script.push_back('{16'h5555, 16'hAAAA, 16'h0F0F, 0, 0, '0});
    script.push_back('{16'hAAAA, 16'h5555, 16'hF0F0, 0, 0, '0});
    script.push_back('{16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, '0});
    script.push_back('{16'h0000, 16'h0000, 16'h0000, 1, 0, '0});
    script.push_back('{16'h1234, 16'h8000, 16'h7FFF, 1, 0, '0});

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i])
      send_vertex(script[i].vx, script[i].vy, script[i].vz, script[i].last,
                  script[i].typed, script[i].want);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        settle();
        configure(phase);
      end
      calm = (phase == CALM_PHASE);
      sent = 0;
      while (sent < PHASE_VERTICES) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(6, 1);
        for (int v = 0; v < len; v++)
          send_vertex(rand_coord(), rand_coord(), rand_coord(), v == len - 1, 1'b0, '0);
        sent += len;
      end
    end
    calm = 1'b0;

    in_tvalid <= 1'b0;
    while (bounds_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && bounds_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
